>>> design/ufcv_pkg.sv
// ----------------------------------------------------------------------------
// UDP frame checksum verifier package
// Shared status codes, the frame summary handed from the parser to the result
// stage, and the ones-complement adder.
// ----------------------------------------------------------------------------
`default_nettype none

package ufcv_pkg;

  localparam int unsigned EthHdrBytes = 14;
  localparam int unsigned PosWidth    = 17;

  typedef enum logic [2:0] {
    ST_MATCH       = 3'd0,
    ST_MISMATCH    = 3'd1,
    ST_NOT_IPV4    = 3'd2,
    ST_BAD_VERSION = 3'd3,
    ST_HDR_SHORT   = 3'd4,
    ST_HDR_LONG    = 3'd5,
    ST_NOT_UDP     = 3'd6,
    ST_TRUNCATED   = 3'd7
  } status_e;

  typedef struct packed {
    logic [15:0]         run_sum;
    logic [7:0]          pend_byte;
    logic [15:0]         tot_len;
    logic [3:0]          hdr_words;
    logic [PosWidth-1:0] byte_count;
    status_e             err_code;
    logic [15:0]         rx_cksum;
    logic [7:0]          ttl;
    logic [31:0]         src_addr;
  } summary_t;

  // Ones-complement 16-bit addition with end-around carry.
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

`default_nettype wire

>>> design/udp_ipv4_frame_checksum_verifier_unit.sv
// ----------------------------------------------------------------------------
// UDP over IPv4 frame checksum verifier
// Checks the IPv4 and UDP headers of an Ethernet frame and verifies the UDP
// checksum over the pseudo header and segment, one result per frame.
//
//   Channel   Direction  Handshake                  Payload
//   input     in         in_valid_i / in_ready_o    data_byte_i, frame_end_i
//   result    out        out_valid_o / out_ready_i  status_o, computed_sum_o,
//                                                   received_sum_o,
//                                                   time_to_live_o,
//                                                   source_address_o
//
// One byte is taken per cycle while in_ready_o is high; the byte parser
// updates its state in the cycle the byte is accepted. The result of a frame
// passes through the summary register and then the output register.
// Reset clears the frame state, so the first accepted byte is the first byte
// of a frame. A stalled result only blocks input once both the summary and
// the output register are full.
// ----------------------------------------------------------------------------
`default_nettype none

module udp_ipv4_frame_checksum_verifier_unit
  import ufcv_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        frame_end_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o,
  output logic [15:0]      computed_sum_o,
  output logic [15:0]      received_sum_o,
  output logic [7:0]       time_to_live_o,
  output logic [31:0]      source_address_o
);

  logic     sum_valid;
  logic     sum_ready;
  summary_t summary;

  ufcv_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .frame_end_i (frame_end_i),
    .sum_valid_o (sum_valid),
    .sum_ready_i (sum_ready),
    .summary_o   (summary)
  );

  ufcv_final u_final (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .sum_valid_i      (sum_valid),
    .sum_ready_o      (sum_ready),
    .summary_i        (summary),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .computed_sum_o   (computed_sum_o),
    .received_sum_o   (received_sum_o),
    .time_to_live_o   (time_to_live_o),
    .source_address_o (source_address_o)
  );

endmodule

`default_nettype wire

>>> design/ufcv_parse.sv
// ----------------------------------------------------------------------------
// UDP frame checksum verifier byte parser
// Walks the frame one byte per cycle while ready, runs the header checks,
// captures the header fields and keeps the running ones-complement sum. On the
// final byte it loads a frame summary register and clears itself for the next frame.
// ----------------------------------------------------------------------------
`default_nettype none

module ufcv_parse
  import ufcv_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic     frame_end_i,
  output logic          sum_valid_o,
  input  wire logic     sum_ready_i,
  output summary_t      summary_o
);

  localparam logic [PosWidth-1:0] PosMax     = {PosWidth{1'b1}};
  localparam logic [PosWidth-1:0] PosEtypeHi = PosWidth'(12);
  localparam logic [PosWidth-1:0] PosEtypeLo = PosWidth'(13);
  localparam logic [PosWidth-1:0] PosVerIhl  = PosWidth'(14);
  localparam logic [PosWidth-1:0] PosLenHi   = PosWidth'(16);
  localparam logic [PosWidth-1:0] PosLenLo   = PosWidth'(17);
  localparam logic [PosWidth-1:0] PosTtl     = PosWidth'(22);
  localparam logic [PosWidth-1:0] PosProto   = PosWidth'(23);
  localparam logic [PosWidth-1:0] PosSrcLo   = PosWidth'(26);
  localparam logic [PosWidth-1:0] PosSrcHi   = PosWidth'(29);
  localparam logic [PosWidth-1:0] PosDstHi   = PosWidth'(33);
  localparam logic [PosWidth-1:0] HdrBase    = PosWidth'(EthHdrBytes);
  localparam logic [15:0]         EtypeIpv4  = 16'h0800;
  localparam logic [7:0]          ProtoUdp   = 8'd17;

  logic [PosWidth-1:0] pos_q, pos_d;
  logic [15:0]         sum_q, sum_d;
  logic [7:0]          pend_q, pend_d;
  logic [3:0]          hw_q, hw_d;
  logic [15:0]         tl_q, tl_d;
  logic [15:0]         ck_q, ck_d;
  logic [7:0]          ttl_q, ttl_d;
  logic [31:0]         src_q, src_d;
  status_e             err_q, err_d;

  logic                sum_valid_q;
  summary_t            summary_q;

  logic                accept;
  logic [PosWidth-1:0] udp_start;
  logic [PosWidth-1:0] ip_end;
  logic                summed;
  logic                add_proto;
  logic [7:0]          v;
  logic [15:0]         sum_a;

  assign in_ready_o  = !sum_valid_q || sum_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign sum_valid_o = sum_valid_q;
  assign summary_o   = summary_q;

  always_comb begin
    udp_start = HdrBase + {{(PosWidth-6){1'b0}}, hw_q, 2'b00};
    ip_end    = HdrBase + {{(PosWidth-16){1'b0}}, tl_q};
    pend_d    = pend_q;
    hw_d      = hw_q;
    tl_d      = tl_q;
    ck_d      = ck_q;
    ttl_d     = ttl_q;
    src_d     = src_q;
    err_d     = err_q;
    summed    = 1'b0;
    add_proto = 1'b0;
    v         = data_byte_i;

    case (pos_q)
      PosEtypeHi: begin
        pend_d = data_byte_i;
      end
      PosEtypeLo: begin
        if ({pend_q, data_byte_i} != EtypeIpv4 && err_d == ST_MATCH) err_d = ST_NOT_IPV4;
        pend_d = 8'd0;
      end
      PosVerIhl: begin
        if (data_byte_i[7:4] != 4'd4 && err_d == ST_MATCH) err_d = ST_BAD_VERSION;
        hw_d = data_byte_i[3:0];
        if (hw_d < 4'd5 && err_d == ST_MATCH) err_d = ST_HDR_SHORT;
      end
      PosLenHi: begin
        tl_d = {data_byte_i, 8'h00};
      end
      PosLenLo: begin
        tl_d = {tl_q[15:8], data_byte_i};
        if ({12'd0, hw_q} >= tl_d && err_d == ST_MATCH) err_d = ST_HDR_LONG;
      end
      PosTtl: begin
        ttl_d = data_byte_i;
      end
      PosProto: begin
        if (data_byte_i != ProtoUdp && err_d == ST_MATCH) err_d = ST_NOT_UDP;
        add_proto = 1'b1;
      end
      default: begin
      end
    endcase

    if (pos_q >= PosSrcLo && pos_q <= PosSrcHi) begin
      src_d = {src_q[23:0], data_byte_i};
    end
    if (pos_q >= PosSrcLo && pos_q <= PosDstHi) begin
      summed = 1'b1;
    end
    if (pos_q > PosLenLo && pos_q >= udp_start && pos_q < ip_end) begin
      summed = 1'b1;
      if (pos_q == udp_start + PosWidth'(6)) begin
        ck_d = {data_byte_i, ck_q[7:0]};
        v    = 8'd0;
      end else if (pos_q == udp_start + PosWidth'(7)) begin
        ck_d = {ck_q[15:8], data_byte_i};
        v    = 8'd0;
      end
    end

    sum_a = add_proto ? oc_add(sum_q, {8'd0, ProtoUdp}) : sum_q;
    sum_d = sum_a;
    if (summed) begin
      if (!pos_q[0]) begin
        pend_d = v;
      end else begin
        sum_d  = oc_add(sum_a, {pend_q, v});
        pend_d = 8'd0;
      end
    end

    pos_d = (pos_q == PosMax) ? pos_q : pos_q + PosWidth'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      sum_q  <= '0;
      pend_q <= '0;
      hw_q   <= '0;
      tl_q   <= '0;
      ck_q   <= '0;
      ttl_q  <= '0;
      src_q  <= '0;
      err_q  <= ST_MATCH;
    end else if (accept) begin
      if (frame_end_i) begin
        pos_q  <= '0;
        sum_q  <= '0;
        pend_q <= '0;
        hw_q   <= '0;
        tl_q   <= '0;
        ck_q   <= '0;
        ttl_q  <= '0;
        src_q  <= '0;
        err_q  <= ST_MATCH;
      end else begin
        pos_q  <= pos_d;
        sum_q  <= sum_d;
        pend_q <= pend_d;
        hw_q   <= hw_d;
        tl_q   <= tl_d;
        ck_q   <= ck_d;
        ttl_q  <= ttl_d;
        src_q  <= src_d;
        err_q  <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q <= 1'b0;
    end else if (accept && frame_end_i) begin
      sum_valid_q <= 1'b1;
    end else if (sum_ready_i) begin
      sum_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && frame_end_i) begin
      summary_q.run_sum    <= sum_d;
      summary_q.pend_byte  <= pend_d;
      summary_q.tot_len    <= tl_d;
      summary_q.hdr_words  <= hw_d;
      summary_q.byte_count <= pos_d;
      summary_q.err_code   <= err_d;
      summary_q.rx_cksum   <= ck_d;
      summary_q.ttl        <= ttl_d;
      summary_q.src_addr   <= src_d;
    end
  end

  // The final byte of a frame always produces a summary in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && frame_end_i |=> sum_valid_q)
    else $error("frame end did not load the summary register");

  // The parser starts every frame from byte zero with a clean sum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && frame_end_i |=> pos_q == '0 && sum_q == '0 && err_q == ST_MATCH)
    else $error("parser state not cleared after frame end");

  // Once an error is recorded, it is kept until the frame ends.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q != ST_MATCH && !(accept && frame_end_i) |=> err_q == $past(err_q))
    else $error("recorded error code was overwritten");

endmodule

`default_nettype wire

>>> design/ufcv_final.sv
// ----------------------------------------------------------------------------
// UDP frame checksum verifier result stage
// Closes the ones-complement sum with the open byte and the UDP length,
// decides the frame status and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ufcv_final
  import ufcv_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     sum_valid_i,
  output logic          sum_ready_o,
  input  wire summary_t summary_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output logic [2:0]    status_o,
  output logic [15:0]   computed_sum_o,
  output logic [15:0]   received_sum_o,
  output logic [7:0]    time_to_live_o,
  output logic [31:0]   source_address_o
);

  logic                out_valid_q;
  status_e             status_q;
  logic [15:0]         computed_q;
  logic [15:0]         received_q;
  logic [7:0]          ttl_q;
  logic [31:0]         src_q;

  logic                load;
  logic [15:0]         hdr_bytes;
  logic [15:0]         udp_len;
  logic [15:0]         sum1;
  logic [15:0]         sum2;
  logic [15:0]         computed;
  logic [15:0]         need;
  logic [PosWidth-1:0] limit;
  status_e             status;

  assign sum_ready_o = !out_valid_q || out_ready_i;
  assign load        = sum_valid_i && sum_ready_o;

  always_comb begin
    hdr_bytes = {10'd0, summary_i.hdr_words, 2'b00};
    udp_len   = summary_i.tot_len - hdr_bytes;
    sum1      = oc_add(summary_i.run_sum, {summary_i.pend_byte, 8'h00});
    sum2      = oc_add(sum1, udp_len);
    computed  = ~sum2;
    need      = (summary_i.tot_len > hdr_bytes) ? summary_i.tot_len : hdr_bytes;
    limit     = PosWidth'(EthHdrBytes) + {{(PosWidth-16){1'b0}}, need};
    if (summary_i.err_code != ST_MATCH) begin
      status = summary_i.err_code;
    end else if (summary_i.byte_count < limit) begin
      status = ST_TRUNCATED;
    end else if (computed == summary_i.rx_cksum ||
                 (computed == 16'h0000 && summary_i.rx_cksum == 16'hFFFF)) begin
      status = ST_MATCH;
    end else begin
      status = ST_MISMATCH;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q   <= status;
      computed_q <= computed;
      received_q <= summary_i.rx_cksum;
      ttl_q      <= summary_i.ttl;
      src_q      <= summary_i.src_addr;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign computed_sum_o   = computed_q;
  assign received_sum_o   = received_q;
  assign time_to_live_o   = ttl_q;
  assign source_address_o = src_q;

  // A match is only reported when the two checksums agree or the computed sum is 0000 and the received one FFFF.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q == ST_MATCH |->
      computed_q == received_q || (computed_q == 16'h0000 && received_q == 16'hFFFF))
    else $error("match reported for differing checksums");

endmodule

`default_nettype wire
